// File: src/ntc_beta_temperature_macros.svh
// Assertion macros shared by the NTC temperature block.
`ifndef NTC_BETA_TEMPERATURE_MACROS_SVH
`define NTC_BETA_TEMPERATURE_MACROS_SVH

// Same-cycle implication, checked at every clock edge outside reset.
`define NTCB_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define NTCB_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: src/ntcb_pkg.sv
// Types, widths, constants and the log table of the NTC temperature block.
`default_nettype none
package ntcb_pkg;

	localparam int ADC_BITS = 12;

	localparam int PU_W   = 20;
	localparam int NOM_W  = 20;
	localparam int BETA_W = 14;
	localparam int T0_W   = 16;
	localparam int FS_W   = 12;
	localparam int VREF_W = 13;
	localparam int CFG_W  = 20;
	localparam int IDX_W  = 3;

	localparam int TEMP_W = 16;
	localparam int VOLT_W = 13;

	localparam int CMP_W  = (ADC_BITS > FS_W) ? ADC_BITS : FS_W;
	localparam int PU_PW  = PU_W + ADC_BITS;
	localparam int DN_PW  = CMP_W + NOM_W;
	localparam int SV_PW  = ADC_BITS + VREF_W;

	// divider chain geometry
	localparam int STEPS  = 33;
	localparam int QUO_W  = STEPS;
	localparam int DEN_W  = 38;
	localparam int NUM_W  = 55;

	localparam int B100_W = 21;
	localparam int BT_W   = B100_W + T0_W;
	localparam int LNV_W  = 21;
	localparam int LNT_W  = 38;
	localparam int D_W    = 39;

	localparam int PIPE_LAT = 2 * (STEPS + 1) + 11;

	localparam logic [15:0] LN2_Q16      = 16'd45426;
	localparam logic [16:0] ZERO_C_CENTI = 17'd27315;
	localparam logic [16:0] TC_MAX       = 17'd60082;
	localparam logic signed [TEMP_W-1:0] TEMP_FAULT = 16'sh8000;
	localparam logic signed [TEMP_W-1:0] TEMP_HOT   = 16'sh7FFF;

	typedef enum logic [IDX_W-1:0] {
		REG_PULLUP  = 3'd0,
		REG_NOMINAL = 3'd1,
		REG_BETA    = 3'd2,
		REG_T0      = 3'd3,
		REG_FS      = 3'd4,
		REG_VREF    = 3'd5
	} reg_idx_t;

	typedef struct packed {
		logic              dpos;
		logic              fault;
		logic [VOLT_W-1:0] volt;
	} side_t;

	typedef struct packed {
		logic             valid;
		logic             ovf;
		logic [DEN_W-1:0] rem;
		logic [QUO_W-1:0] low;
		logic [DEN_W-1:0] den;
		logic [QUO_W-1:0] quo;
		side_t            side;
	} div_lane_t;

	// ln(1 + i/16) in Q16.16
	function automatic logic [15:0] ln_tab(input logic [4:0] idx);
		logic [15:0] v;
		case (idx)
			5'd0:  v = 16'd0;
			5'd1:  v = 16'd3973;
			5'd2:  v = 16'd7719;
			5'd3:  v = 16'd11262;
			5'd4:  v = 16'd14624;
			5'd5:  v = 16'd17821;
			5'd6:  v = 16'd20870;
			5'd7:  v = 16'd23783;
			5'd8:  v = 16'd26573;
			5'd9:  v = 16'd29248;
			5'd10: v = 16'd31818;
			5'd11: v = 16'd34292;
			5'd12: v = 16'd36675;
			5'd13: v = 16'd38975;
			5'd14: v = 16'd41196;
			5'd15: v = 16'd43345;
			5'd16: v = 16'd45426;
			default: v = 16'd0;
		endcase
		return v;
	endfunction

endpackage
`default_nettype wire

// File: src/ntc_beta_temperature.sv
// Top level: NTC divider sample to temperature (beta equation) and millivolts.
// Usage:
//   Pulse start with a sample; busy is never raised, so a sample is taken in
//   every cycle that start is high. Each sample yields one result on
//   temperature_centi, voltage_mv and fault, marked by done for one cycle.
//   Results leave in the same spacing and order as the samples; one per cycle.
//   The latency is set by two 33-cell divider rows (ratio and then the
//   temperature quotient, each one bit per cell) plus the log and multiply
//   stages between them. The voltage division runs in a parallel row.
//   The receiver cannot stall; results are not held.
//   Registers are written through wr_en / wr_index / wr_data, taking effect
//   on the next edge; write them only while no transaction is in flight.
//   Reset clears all in-flight transactions and loads the default register
//   values (10k pull-up, 10k at 298.15 K, beta 3950, 12-bit, 3300 mV).
//   fault marks a sample of 0 or at/above full scale; the temperature code
//   is then -32768 while voltage_mv is still computed.
`default_nettype none
`include "ntc_beta_temperature_macros.svh"
module ntc_beta_temperature
	import ntcb_pkg::*;
(
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     start,
	output logic                          busy,
	input  wire logic [ADC_BITS-1:0]      sample,
	output logic                          done,
	output logic signed [TEMP_W-1:0]      temperature_centi,
	output logic [VOLT_W-1:0]             voltage_mv,
	output logic                          fault,
	input  wire logic                     wr_en,
	input  wire logic [IDX_W-1:0]         wr_index,
	input  wire logic [CFG_W-1:0]         wr_data
);

	logic [PU_W-1:0]   pullup_q;
	logic [NOM_W-1:0]  nominal_q;
	logic [BETA_W-1:0] beta_q;
	logic [T0_W-1:0]   t0_q;
	logic [FS_W-1:0]   fs_q;
	logic [VREF_W-1:0] vref_q;
	logic [B100_W-1:0] b100_q;

	logic                acc;
	logic                valid_s1;
	logic [ADC_BITS-1:0] sample_s1;

	logic             fault_w;
	logic             valid_s2;
	logic             fault_s2;
	logic [PU_PW-1:0] pu_s2;
	logic [DN_PW-1:0] dn_s2;
	logic [SV_PW-1:0] sv_s2;

	div_lane_t lane_q_out;
	div_lane_t lane_v_out;
	side_t     side_q_in;
	side_t     side_v_in;

	logic [31:0]       ratio_w;
	logic [VOLT_W-1:0] volt_w;
	logic              valid_p1;
	logic [31:0]       ratio_p1;
	side_t             side_p1;

	logic                    ln_valid;
	logic signed [LNV_W-1:0] ln_val;
	side_t                   ln_side;

	logic                    valid_t2;
	logic signed [LNT_W-1:0] lnt_t2;
	logic [BT_W-1:0]         bt_t2;
	side_t                   side_t2;

	logic                    valid_t3;
	logic signed [D_W-1:0]   d_t3;
	logic [BT_W+15:0]        n_t3;
	side_t                   side_t3;

	logic             valid_t4;
	logic [NUM_W-1:0] nh_t4;
	logic [DEN_W-1:0] den_t4;
	side_t            side_t4;
	side_t            side_t4_w;

	div_lane_t lane_t_out;

	logic                     sat_w;
	logic [17:0]              tdiff_w;
	logic signed [TEMP_W-1:0] temp_w;
	logic                     done_q;
	logic signed [TEMP_W-1:0] temp_q;
	logic [VOLT_W-1:0]        volt_q;
	logic                     fault_q;

	// ---------------- configuration ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pullup_q  <= 20'd10000;
			nominal_q <= 20'd10000;
			beta_q    <= 14'd3950;
			t0_q      <= 16'd29815;
			fs_q      <= 12'd4095;
			vref_q    <= 13'd3300;
			b100_q    <= 21'd395000;
		end else begin
			b100_q <= B100_W'(beta_q) * B100_W'(7'd100);
			if (wr_en) begin
				case (wr_index)
					REG_PULLUP:  pullup_q  <= wr_data[PU_W-1:0];
					REG_NOMINAL: nominal_q <= wr_data[NOM_W-1:0];
					REG_BETA:    beta_q    <= wr_data[BETA_W-1:0];
					REG_T0:      t0_q      <= wr_data[T0_W-1:0];
					REG_FS:      fs_q      <= wr_data[FS_W-1:0];
					REG_VREF:    vref_q    <= wr_data[VREF_W-1:0];
					default:     ;
				endcase
			end
		end
	end

	assign busy = 1'b0;
	assign acc  = start && !busy;

	// ---------------- input and products ----------------
	assign fault_w = (sample_s1 == '0) || (CMP_W'(sample_s1) >= CMP_W'(fs_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_p1 <= 1'b0;
			valid_t2 <= 1'b0;
			valid_t3 <= 1'b0;
			valid_t4 <= 1'b0;
			done_q   <= 1'b0;
		end else begin
			valid_s1 <= acc;
			valid_s2 <= valid_s1;
			valid_p1 <= lane_q_out.valid;
			valid_t2 <= ln_valid;
			valid_t3 <= valid_t2;
			valid_t4 <= valid_t3;
			done_q   <= lane_t_out.valid;
		end
	end

	always_ff @(posedge clk) begin
		sample_s1 <= sample;
		fault_s2  <= fault_w;
		pu_s2     <= PU_PW'(pullup_q) * PU_PW'(sample_s1);
		dn_s2     <= DN_PW'(CMP_W'(fs_q) - CMP_W'(sample_s1)) * DN_PW'(nominal_q);
		sv_s2     <= SV_PW'(sample_s1) * SV_PW'(vref_q);
	end

	// ---------------- ratio and voltage divider rows ----------------
	always_comb begin
		side_q_in       = '0;
		side_q_in.fault = fault_s2;
		side_v_in       = '0;
	end

	ntcb_div_chain u_div_ratio (
		.clk     (clk),
		.arst_n  (arst_n),
		.valid_i (valid_s2),
		.num_i   (NUM_W'({pu_s2, 16'b0})),
		.den_i   (DEN_W'(dn_s2)),
		.side_i  (side_q_in),
		.lane_o  (lane_q_out)
	);

	ntcb_div_chain u_div_volt (
		.clk     (clk),
		.arst_n  (arst_n),
		.valid_i (valid_s2),
		.num_i   (NUM_W'(sv_s2)),
		.den_i   (DEN_W'(fs_q)),
		.side_i  (side_v_in),
		.lane_o  (lane_v_out)
	);

	always_comb begin
		if (lane_q_out.ovf || lane_q_out.quo[QUO_W-1]) ratio_w = '1;
		else                                           ratio_w = lane_q_out.quo[31:0];
		if (ratio_w == '0) ratio_w = 32'd1;

		if (fs_q == '0)
			volt_w = '0;
		else if (lane_v_out.quo > QUO_W'({VOLT_W{1'b1}}))
			volt_w = '1;
		else
			volt_w = lane_v_out.quo[VOLT_W-1:0];
	end

	always_ff @(posedge clk) begin
		ratio_p1      <= ratio_w;
		side_p1.dpos  <= 1'b0;
		side_p1.fault <= lane_q_out.side.fault;
		side_p1.volt  <= volt_w;
	end

	// ---------------- log ----------------
	ntcb_ln u_ln (
		.clk     (clk),
		.arst_n  (arst_n),
		.valid_i (valid_p1),
		.ratio_i (ratio_p1),
		.side_i  (side_p1),
		.valid_o (ln_valid),
		.lnv_o   (ln_val),
		.side_o  (ln_side)
	);

	// ---------------- beta equation terms ----------------
	always_comb begin
		side_t4_w      = side_t3;
		side_t4_w.dpos = !d_t3[D_W-1] && (d_t3 != '0);
	end

	always_ff @(posedge clk) begin
		lnt_t2  <= LNT_W'(ln_val) * LNT_W'($signed({1'b0, t0_q}));
		bt_t2   <= BT_W'(b100_q) * BT_W'(t0_q);
		side_t2 <= ln_side;

		d_t3    <= $signed({2'b00, b100_q, 16'b0}) + D_W'(lnt_t2);
		n_t3    <= {bt_t2, 16'b0};
		side_t3 <= side_t2;

		// numerator plus half the divisor for round to nearest
		nh_t4   <= NUM_W'(n_t3) + NUM_W'(d_t3[D_W-1:1]);
		den_t4  <= d_t3[DEN_W-1:0];
		side_t4 <= side_t4_w;
	end

	ntcb_div_chain u_div_temp (
		.clk     (clk),
		.arst_n  (arst_n),
		.valid_i (valid_t4),
		.num_i   (nh_t4),
		.den_i   (den_t4),
		.side_i  (side_t4),
		.lane_o  (lane_t_out)
	);

	// ---------------- result ----------------
	always_comb begin
		sat_w   = !lane_t_out.side.dpos || lane_t_out.ovf ||
		          (lane_t_out.quo > QUO_W'(TC_MAX));
		tdiff_w = {1'b0, lane_t_out.quo[16:0]} - {1'b0, ZERO_C_CENTI};
		if (lane_t_out.side.fault) temp_w = TEMP_FAULT;
		else if (sat_w)            temp_w = TEMP_HOT;
		else                       temp_w = $signed(tdiff_w[TEMP_W-1:0]);
	end

	always_ff @(posedge clk) begin
		temp_q  <= temp_w;
		volt_q  <= lane_t_out.side.volt;
		fault_q <= lane_t_out.side.fault;
	end

	assign done              = done_q;
	assign temperature_centi = temp_q;
	assign voltage_mv        = volt_q;
	assign fault             = fault_q;

	`NTCB_ASSERT_IMP(a_done_latency, done, $past(acc, PIPE_LAT), "result without a sample")
	`NTCB_ASSERT_IMP(a_fault_code, done && fault, temperature_centi == TEMP_FAULT, "fault code")
	`NTCB_ASSERT_IMP(a_nonzero_ok, done && !fault, $past(sample, PIPE_LAT) != '0, "zero not faulted")
	`NTCB_ASSERT_NXT(a_ratio_flow, lane_q_out.valid, valid_p1, "ratio row result dropped")

endmodule
`default_nettype wire

// File: src/ntcb_div_cell.sv
// One restoring division step: shifts in a dividend bit, emits a quotient bit.
`default_nettype none
module ntcb_div_cell
	import ntcb_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire div_lane_t lane_i,
	output div_lane_t      lane_o
);

	logic [DEN_W:0]   t;
	logic [DEN_W:0]   dif;
	logic             ge;
	div_lane_t        nxt;
	logic             valid_q;
	div_lane_t        data_q;

	always_comb begin
		t   = {lane_i.rem, lane_i.low[QUO_W-1]};
		dif = t - {1'b0, lane_i.den};
		ge  = (t >= {1'b0, lane_i.den});
		nxt = lane_i;
		nxt.rem = ge ? dif[DEN_W-1:0] : t[DEN_W-1:0];
		nxt.low = {lane_i.low[QUO_W-2:0], 1'b0};
		nxt.quo = {lane_i.quo[QUO_W-2:0], ge};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= lane_i.valid;
		end
	end

	always_ff @(posedge clk) begin
		data_q <= nxt;
	end

	always_comb begin
		lane_o       = data_q;
		lane_o.valid = valid_q;
	end

endmodule
`default_nettype wire

// File: src/ntcb_div_chain.sv
// Divider row: launch register with overflow check, then one cell per quotient bit.
`default_nettype none
module ntcb_div_chain
	import ntcb_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             valid_i,
	input  wire logic [NUM_W-1:0] num_i,
	input  wire logic [DEN_W-1:0] den_i,
	input  wire side_t            side_i,
	output div_lane_t             lane_o
);

	logic [DEN_W-1:0] hi;
	logic             ovf;
	logic             valid_q;
	div_lane_t        launch_q;
	div_lane_t        lane [STEPS+1];

	// quotient wider than the row means the top dividend bits already reach the divisor
	assign hi  = DEN_W'(num_i[NUM_W-1:QUO_W]);
	assign ovf = (hi >= den_i);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= valid_i;
		end
	end

	always_ff @(posedge clk) begin
		launch_q.valid <= 1'b0;
		launch_q.ovf   <= ovf;
		launch_q.rem   <= ovf ? '0 : hi;
		launch_q.low   <= num_i[QUO_W-1:0];
		launch_q.den   <= den_i;
		launch_q.quo   <= '0;
		launch_q.side  <= side_i;
	end

	always_comb begin
		lane[0]       = launch_q;
		lane[0].valid = valid_q;
	end

	for (genvar g = 0; g < STEPS; g++) begin : g_cell
		ntcb_div_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.lane_i (lane[g]),
			.lane_o (lane[g+1])
		);
	end

	assign lane_o = lane[STEPS];

endmodule
`default_nettype wire

// File: src/ntcb_ln.sv
// Natural log of a Q16.16 ratio: normalize, table lookup, linear interpolation.
`default_nettype none
module ntcb_ln
	import ntcb_pkg::*;
(
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    valid_i,
	input  wire logic [31:0]             ratio_i,
	input  wire side_t                   side_i,
	output logic                         valid_o,
	output logic signed [LNV_W-1:0]      lnv_o,
	output side_t                        side_o
);

	logic [3:0]  valid_q;

	logic [4:0]  p_w;
	logic [4:0]  p_s1;
	logic [31:0] q_s1;
	side_t       side_s1;

	logic [31:0] m_w;
	logic [15:0] f_w;
	logic [4:0]  idx_w;
	logic [15:0] ta_w;
	logic [15:0] tb_w;
	logic [15:0] ti_s2;
	logic [11:0] dif_s2;
	logic [11:0] w_s2;
	logic [4:0]  p_s2;
	side_t       side_s2;

	logic signed [6:0]  pm_w;
	logic signed [23:0] base_w;
	logic [23:0]        prod_s3;
	logic signed [23:0] base_s3;
	side_t              side_s3;

	logic [24:0]        rnd_w;
	logic signed [23:0] sum_w;
	logic signed [LNV_W-1:0] lnv_s4;
	side_t              side_s4;

	// leading one
	always_comb begin
		p_w = '0;
		for (int k = 0; k < 32; k++) begin
			if (ratio_i[k]) p_w = 5'(k);
		end
	end

	always_comb begin
		if (p_s1 >= 5'd16) m_w = q_s1 >> (p_s1 - 5'd16);
		else               m_w = q_s1 << (5'd16 - p_s1);
		f_w   = m_w[15:0];
		idx_w = {1'b0, f_w[15:12]};
		ta_w  = ln_tab(idx_w);
		tb_w  = ln_tab(idx_w + 5'd1);
	end

	always_comb begin
		pm_w   = $signed({2'b00, p_s2}) - 7'sd16;
		base_w = pm_w * $signed({8'b0, LN2_Q16}) + $signed({8'b0, ti_s2});
	end

	always_comb begin
		rnd_w = {1'b0, prod_s3} + 25'd2048;
		sum_w = base_s3 + $signed({11'b0, rnd_w[24:12]});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else begin
			valid_q <= {valid_q[2:0], valid_i};
		end
	end

	always_ff @(posedge clk) begin
		p_s1    <= p_w;
		q_s1    <= ratio_i;
		side_s1 <= side_i;

		ti_s2   <= ta_w;
		dif_s2  <= 12'(tb_w - ta_w);
		w_s2    <= f_w[11:0];
		p_s2    <= p_s1;
		side_s2 <= side_s1;

		prod_s3 <= 24'(dif_s2) * 24'(w_s2);
		base_s3 <= base_w;
		side_s3 <= side_s2;

		lnv_s4  <= sum_w[LNV_W-1:0];
		side_s4 <= side_s3;
	end

	assign valid_o = valid_q[3];
	assign lnv_o   = lnv_s4;
	assign side_o  = side_s4;

endmodule
`default_nettype wire

// File: test/ntc_beta_temperature_tb.sv
// Testbench for the NTC beta-equation temperature block: predicts each result and compares.
`timescale 1ns / 1ps
module ntc_beta_temperature_tb;
	import ntcb_pkg::*;

	typedef struct {
		logic signed [TEMP_W-1:0] temp;
		logic [VOLT_W-1:0]        volt;
		logic                     flt;
	} reading_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic [ADC_BITS-1:0] sample = '0;
	logic wr_en = 1'b0;
	logic [IDX_W-1:0] wr_index = '0;
	logic [CFG_W-1:0] wr_data = '0;
	logic busy, done, fault;
	logic signed [TEMP_W-1:0] temperature_centi;
	logic [VOLT_W-1:0] voltage_mv;

	ntc_beta_temperature u_top (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .sample(sample),
		.done(done), .temperature_centi(temperature_centi), .voltage_mv(voltage_mv),
		.fault(fault), .wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data)
	);

	always #6 clk = ~clk;

	// register shadow
	logic [PU_W-1:0]   pu_ohms;
	logic [NOM_W-1:0]  nom_ohms;
	logic [BETA_W-1:0] beta_k;
	logic [T0_W-1:0]   t0_ck;
	logic [FS_W-1:0]   fs_code;
	logic [VREF_W-1:0] vref;

	logic [ADC_BITS-1:0] sample_q[$];
	reading_t            reading_q[$];
	int mismatches = 0;
	int checked = 0;
	int faults_seen = 0;
	bit stim_done = 0;
	int gap_left = 0;
	int burst_left = 0;

	function automatic longint ln_fix(input longint x);
		int p;
		longint m, f, i, w, t0, t1;
		p = 31;
		while (p > 0 && x[p] == 1'b0) p--;
		if (p >= 16) m = x >> (p - 16);
		else m = x << (16 - p);
		f = m & 64'hFFFF;
		i = f >> 12;
		w = f & 64'hFFF;
		t0 = ln_tab(i[4:0]);
		t1 = ln_tab(i[4:0] + 5'd1);
		return longint'(p - 16) * 45426 + t0 + (((t1 - t0) * w + 2048) >>> 12);
	endfunction

	function automatic reading_t thermistor_reading(input logic [ADC_BITS-1:0] s_in);
		reading_t r;
		longint s, fs, v, num, den, q, lnv, b100, n, d, tc, t;
		s = s_in;
		fs = fs_code;
		v = 0;
		t = -32768;
		if (fs != 0) begin
			v = (s * vref) / fs;
			if (v > 8191) v = 8191;
		end
		r.flt = (s == 0) || (s >= fs);
		if (!r.flt) begin
			num = (longint'(pu_ohms) * s) << 16;
			den = (fs - s) * longint'(nom_ohms);
			if (den == 0) q = 64'hFFFFFFFF;
			else begin
				q = num / den;
				if (q > 64'hFFFFFFFF) q = 64'hFFFFFFFF;
			end
			if (q == 0) q = 1;
			lnv = ln_fix(q);
			b100 = 100 * longint'(beta_k);
			n = b100 * longint'(t0_ck) * 65536;
			d = b100 * 65536 + lnv * longint'(t0_ck);
			if (d <= 0) t = 32767;
			else begin
				tc = (n + d / 2) / d;
				t = tc - 27315;
				if (t > 32767) t = 32767;
			end
		end
		r.temp = t[15:0];
		r.volt = v[12:0];
		return r;
	endfunction

	// driver: bursts and gaps; takes from sample_q
	always @(posedge clk) begin
		if (arst_n && start && !busy) begin
			reading_q.push_back(thermistor_reading(sample));
			void'(sample_q.pop_front());
		end
		if (!arst_n) begin
			start <= 1'b0;
		end else begin
			logic go;
			go = 1'b0;
			if (gap_left > 0) gap_left--;
			else if (burst_left == 0) begin
				if ($urandom_range(0, 3) == 0) burst_left = $urandom_range(1, 40);
				else begin
					burst_left = $urandom_range(1, 12);
					gap_left = $urandom_range(0, 6);
				end
			end
			// queue head moves only after acceptance, so index depends on this edge's take
			if (gap_left == 0 && burst_left > 0 && sample_q.size() > 0) begin
				go = 1'b1;
				burst_left--;
			end
			start <= go;
			if (go) sample <= sample_q[0];
		end
	end

	// monitor
	always @(posedge clk) begin
		if (arst_n && done) begin
			reading_t e;
			if (reading_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected transaction: t=%0d v=%0d f=%0b",
					temperature_centi, voltage_mv, fault);
			end else begin
				e = reading_q.pop_front();
				checked++;
				if (e.flt) faults_seen++;
				if (temperature_centi !== e.temp || voltage_mv !== e.volt || fault !== e.flt) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: exp t=%0d v=%0d f=%0b got t=%0d v=%0d f=%0b",
							e.temp, e.volt, e.flt, temperature_centi, voltage_mv, fault);
				end
			end
		end
	end

	task automatic settle();
		wait (sample_q.size() == 0);
		@(posedge clk);
		@(posedge clk);
		wait (reading_q.size() == 0);
		repeat (PIPE_LAT + 5) @(posedge clk);
	endtask

	task automatic write_reg(input reg_idx_t idx, input logic [CFG_W-1:0] val);
		@(posedge clk);
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= val;
		@(posedge clk);
		wr_en <= 1'b0;
		case (idx)
			REG_PULLUP:  pu_ohms = val[PU_W-1:0];
			REG_NOMINAL: nom_ohms = val[NOM_W-1:0];
			REG_BETA:    beta_k = val[BETA_W-1:0];
			REG_T0:      t0_ck = val[T0_W-1:0];
			REG_FS:      fs_code = val[FS_W-1:0];
			REG_VREF:    vref = val[VREF_W-1:0];
			default: ;
		endcase
	endtask

	task automatic apply_setting(input int pu, input int nom, input int b, input int t0,
			input int fs, input int vr);
		write_reg(REG_PULLUP, CFG_W'(pu));
		write_reg(REG_NOMINAL, CFG_W'(nom));
		write_reg(REG_BETA, CFG_W'(b));
		write_reg(REG_T0, CFG_W'(t0));
		write_reg(REG_FS, CFG_W'(fs));
		write_reg(REG_VREF, CFG_W'(vr));
	endtask

	task automatic random_samples(input int cnt);
		for (int k = 0; k < cnt; k++) begin
			case ($urandom_range(0, 9))
				0: sample_q.push_back('0);
				1: sample_q.push_back(ADC_BITS'(fs_code + $urandom_range(0, 2)));
				2: sample_q.push_back(ADC_BITS'(fs_code - $urandom_range(1, 3)));
				3: sample_q.push_back(ADC_BITS'($urandom_range(1, 8)));
				default: sample_q.push_back(ADC_BITS'($urandom));
			endcase
		end
	endtask

	initial begin
		pu_ohms = 10000; nom_ohms = 10000; beta_k = 3950;
		t0_ck = 29815; fs_code = 4095; vref = 3300;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		// directed: extremes at reset values
		sample_q.push_back(12'd0); sample_q.push_back(12'd1); sample_q.push_back(12'd2);
		sample_q.push_back(12'h555); sample_q.push_back(12'hAAA);
		sample_q.push_back(12'd2048); sample_q.push_back(12'd4094); sample_q.push_back(12'd4095);
		settle();
		// zero full scale, zero nominal, zero pullup, extremes
		apply_setting(0, 0, 1, 1, 0, 1);
		sample_q.push_back(12'd0); sample_q.push_back(12'd5); sample_q.push_back(12'd4095);
		settle();
		apply_setting(1000000, 0, 10000, 65535, 4095, 5000);
		sample_q.push_back(12'd1); sample_q.push_back(12'd2000); sample_q.push_back(12'd4094);
		settle();
		apply_setting(1, 1000000, 10000, 65535, 100, 5000);
		sample_q.push_back(12'd1); sample_q.push_back(12'd50); sample_q.push_back(12'd99);
		sample_q.push_back(12'd4095); // voltage saturation
		settle();
		// random part across several settings, wait for drain after each
		for (int ph = 0; ph < 8; ph++) begin
			case (ph)
				0: apply_setting(10000, 10000, 3950, 29815, 4095, 3300);
				1: apply_setting(1000000, 1, 10000, 65535, 4095, 5000);
				2: apply_setting(1, 1000000, 1, 1, 4095, 1);
				3: apply_setting(100000, 100000, 4250, 29815, 1023, 5000);
				default: apply_setting($urandom_range(1, 1000000), $urandom_range(1, 1000000),
					$urandom_range(1, 10000), $urandom_range(1, 65535),
					$urandom_range(1, 4095), $urandom_range(1, 5000));
			endcase
			if (ph == 5) write_reg(REG_PULLUP, 20'hFFFFF);
			random_samples(104);
			settle();
		end
		stim_done = 1;
		$display("covered %0d transactions (%0d faults) over 12 register settings",
			checked, faults_seen);
		if (mismatches == 0) $display("PASSED: all results match");
		else begin
			$display("%0d mismatches", mismatches);
			$display("FAILED: results differ");
		end
		$finish;
	end

	initial begin
		#5ms;
		$display("FAILED: results differ");
		$finish;
	end
endmodule
